/* rtl/adsrps_pkg.sv */
// Shared types and constants of the ADSR phase sequencer.
package adsrps_pkg;

    localparam int DURATION_BITS_DEF = 24;
    localparam int GATE_BITS         = 2;
    localparam int PHASE_BITS        = 3;
    localparam int M_DATA_BITS       = 8;

    localparam logic [GATE_BITS-1:0] GATE_OFF = 2'd0;
    localparam logic [GATE_BITS-1:0] GATE_ON  = 2'd1;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        logic   active_flag;
        logic   end_pulse;
        logic   start_pulse;
        phase_t phase_code;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

endpackage

/* rtl/adsrps_in_reg.sv */
// Input register stage: holds one accepted word until the phase logic takes it.
module adsrps_in_reg #(
    parameter int DURATION_BITS = adsrps_pkg::DURATION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [adsrps_pkg::GATE_BITS-1:0] in_gate_code,
    input  logic [DURATION_BITS-1:0]         in_attack_length,
    input  logic [DURATION_BITS-1:0]         in_decay_length,
    input  logic [DURATION_BITS-1:0]         in_release_length,
    input  logic                             take,
    output logic                             held_valid,
    output logic [adsrps_pkg::GATE_BITS-1:0] gate_code,
    output logic [DURATION_BITS-1:0]         attack_length,
    output logic [DURATION_BITS-1:0]         decay_length,
    output logic [DURATION_BITS-1:0]         release_length
);

    logic                             valid_reg;
    logic                             valid_next;
    logic                             accept;
    logic [adsrps_pkg::GATE_BITS-1:0] gate_reg;
    logic [DURATION_BITS-1:0]         attack_reg;
    logic [DURATION_BITS-1:0]         decay_reg;
    logic [DURATION_BITS-1:0]         release_reg;

    // The slot frees up in the same cycle that its word moves on.
    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gate_reg    <= in_gate_code;
            attack_reg  <= in_attack_length;
            decay_reg   <= in_decay_length;
            release_reg <= in_release_length;
        end
    end

    assign held_valid     = valid_reg;
    assign gate_code      = gate_reg;
    assign attack_length  = attack_reg;
    assign decay_length   = decay_reg;
    assign release_length = release_reg;

endmodule

/* rtl/adsrps_core.sv */
// Envelope phase state, counters and limits, with the per-sample step logic.
module adsrps_core #(
    parameter int DURATION_BITS = adsrps_pkg::DURATION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic [adsrps_pkg::GATE_BITS-1:0] gate_code,
    input  logic [DURATION_BITS-1:0]         attack_length,
    input  logic [DURATION_BITS-1:0]         decay_length,
    input  logic [DURATION_BITS-1:0]         release_length,
    output adsrps_pkg::result_t              result
);

    localparam logic [DURATION_BITS-1:0] DUR_ONE = DURATION_BITS'(1);

    adsrps_pkg::phase_t       phase_reg;
    adsrps_pkg::phase_t       phase_next;
    adsrps_pkg::phase_t       entry_phase;
    logic                     entry_start;
    logic                     release_done;
    logic [DURATION_BITS-1:0] attack_count_reg;
    logic [DURATION_BITS-1:0] attack_count_next;
    logic [DURATION_BITS-1:0] decay_count_reg;
    logic [DURATION_BITS-1:0] decay_count_next;
    logic [DURATION_BITS-1:0] release_count_reg;
    logic [DURATION_BITS-1:0] release_count_next;
    logic [DURATION_BITS-1:0] attack_limit_reg;
    logic [DURATION_BITS-1:0] attack_limit_next;
    logic [DURATION_BITS-1:0] decay_limit_reg;
    logic [DURATION_BITS-1:0] decay_limit_next;
    logic [DURATION_BITS-1:0] release_limit_reg;
    logic [DURATION_BITS-1:0] release_limit_next;

    function automatic logic [DURATION_BITS-1:0] at_least_one(
        input logic [DURATION_BITS-1:0] v
    );
        return (v == '0) ? DUR_ONE : v;
    endfunction

    // Gate action: decides the phase that is reported for this sample.
    always_comb begin
        entry_phase = phase_reg;
        entry_start = 1'b0;
        if (gate_code == adsrps_pkg::GATE_ON && phase_reg == adsrps_pkg::PH_IDLE) begin
            entry_phase = adsrps_pkg::PH_ATTACK;
            entry_start = 1'b1;
        end else if (gate_code == adsrps_pkg::GATE_OFF &&
                     phase_reg != adsrps_pkg::PH_IDLE &&
                     phase_reg != adsrps_pkg::PH_RELEASE) begin
            entry_phase = adsrps_pkg::PH_RELEASE;
        end
    end

    // Next state: latch limits on entry, then count. A finished attack falls
    // straight into decay, which counts on the same sample.
    always_comb begin
        phase_next         = entry_phase;
        attack_count_next  = attack_count_reg;
        decay_count_next   = decay_count_reg;
        release_count_next = release_count_reg;
        attack_limit_next  = attack_limit_reg;
        decay_limit_next   = decay_limit_reg;
        release_limit_next = release_limit_reg;
        release_done       = 1'b0;

        if (entry_start) begin
            attack_limit_next = at_least_one(attack_length);
            attack_count_next = '0;
        end
        if (entry_phase == adsrps_pkg::PH_RELEASE && phase_reg != adsrps_pkg::PH_RELEASE) begin
            release_limit_next = at_least_one(release_length);
            release_count_next = '0;
        end

        if (phase_next == adsrps_pkg::PH_ATTACK) begin
            attack_count_next = attack_count_next + DUR_ONE;
            if (attack_count_next >= attack_limit_next) begin
                phase_next       = adsrps_pkg::PH_DECAY;
                decay_limit_next = at_least_one(decay_length);
                decay_count_next = '0;
            end
        end
        if (phase_next == adsrps_pkg::PH_DECAY) begin
            decay_count_next = decay_count_next + DUR_ONE;
            if (decay_count_next >= decay_limit_next) begin
                phase_next = adsrps_pkg::PH_SUSTAIN;
            end
        end
        if (phase_next == adsrps_pkg::PH_RELEASE) begin
            release_count_next = release_count_next + DUR_ONE;
            if (release_count_next >= release_limit_next) begin
                phase_next   = adsrps_pkg::PH_IDLE;
                release_done = 1'b1;
            end
        end
    end

    // Outputs of the sample.
    always_comb begin
        result.phase_code  = entry_phase;
        result.start_pulse = entry_start;
        result.end_pulse   = release_done;
        result.active_flag = (entry_phase != adsrps_pkg::PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= adsrps_pkg::PH_IDLE;
            attack_count_reg  <= '0;
            decay_count_reg   <= '0;
            release_count_reg <= '0;
            attack_limit_reg  <= DUR_ONE;
            decay_limit_reg   <= DUR_ONE;
            release_limit_reg <= DUR_ONE;
        end else if (step) begin
            phase_reg         <= phase_next;
            attack_count_reg  <= attack_count_next;
            decay_count_reg   <= decay_count_next;
            release_count_reg <= release_count_next;
            attack_limit_reg  <= attack_limit_next;
            decay_limit_reg   <= decay_limit_next;
            release_limit_reg <= release_limit_next;
        end
    end

endmodule

/* rtl/adsrps_out_reg.sv */
// Result register: holds one finished word until the downstream side takes it.
module adsrps_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  adsrps_pkg::result_t                result,
    output logic                               space,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [adsrps_pkg::M_DATA_BITS-1:0] m_axis_tdata
);

    logic                valid_reg;
    logic                valid_next;
    adsrps_pkg::result_t result_reg;

    // A word leaving in this cycle makes room for the next one.
    assign space = !valid_reg || m_axis_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(adsrps_pkg::M_DATA_BITS - adsrps_pkg::RESULT_BITS){1'b0}},
                            result_reg};

endmodule

/* rtl/adsr_phase_sequencer_unit.sv */
// ADSR phase sequencer top level: input register, phase step logic, result register.
//
// One input word per audio sample gives one result word. The block takes one word
// per clock cycle while the result side keeps up. An accepted word sits in the input
// register while the phase logic works on it, and its result is loaded into the
// result register when the word is taken, which needs room there. The phase logic
// finishes a sample in one combinational step of compares and increments, even when
// it passes from attack through decay to sustain within that sample. The phase, three
// counters and three limits reset to idle, zero and one. While both registers are
// full and the result side holds m_axis_tready low, s_axis_tready is low, and no word
// is lost or repeated. s_axis_tready follows m_axis_tready within the same cycle.
module adsr_phase_sequencer_unit #(
    parameter int DURATION_BITS = adsrps_pkg::DURATION_BITS_DEF,
    localparam int S_FIELD_BITS = adsrps_pkg::GATE_BITS + 3 * DURATION_BITS,
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // gate_code, attack_length, decay_length, release_length, zero padding
    input  logic [S_DATA_BITS-1:0]             s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // phase_code[2:0], start_pulse, end_pulse, active_flag, zero padding
    output logic [adsrps_pkg::M_DATA_BITS-1:0] m_axis_tdata
);

    localparam int GB = adsrps_pkg::GATE_BITS;

    logic                             held_valid;
    logic                             out_space;
    logic                             take;
    logic [GB-1:0]                    gate_code;
    logic [DURATION_BITS-1:0]         attack_length;
    logic [DURATION_BITS-1:0]         decay_length;
    logic [DURATION_BITS-1:0]         release_length;
    adsrps_pkg::result_t              result;

    assign take = held_valid && out_space;

    adsrps_in_reg #(
        .DURATION_BITS(DURATION_BITS)
    ) u_in_reg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .in_gate_code      (s_axis_tdata[GB-1:0]),
        .in_attack_length  (s_axis_tdata[GB+DURATION_BITS-1:GB]),
        .in_decay_length   (s_axis_tdata[GB+2*DURATION_BITS-1:GB+DURATION_BITS]),
        .in_release_length (s_axis_tdata[GB+3*DURATION_BITS-1:GB+2*DURATION_BITS]),
        .take              (take),
        .held_valid        (held_valid),
        .gate_code         (gate_code),
        .attack_length     (attack_length),
        .decay_length      (decay_length),
        .release_length    (release_length)
    );

    adsrps_core #(
        .DURATION_BITS(DURATION_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (take),
        .gate_code      (gate_code),
        .attack_length  (attack_length),
        .decay_length   (decay_length),
        .release_length (release_length),
        .result         (result)
    );

    adsrps_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (take),
        .result        (result),
        .space         (out_space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* rtl/adsrps_checker.sv */
// Port-level checks of the ADSR phase sequencer and their binding to the top level.
module adsrps_checker #(
    parameter int DURATION_BITS = adsrps_pkg::DURATION_BITS_DEF,
    localparam int S_FIELD_BITS = adsrps_pkg::GATE_BITS + 3 * DURATION_BITS,
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [S_DATA_BITS-1:0]             s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [adsrps_pkg::M_DATA_BITS-1:0] m_axis_tdata
);

    logic [adsrps_pkg::PHASE_BITS-1:0] out_phase;
    logic                              out_start;
    logic                              out_end;
    logic                              out_active;

    assign out_phase  = m_axis_tdata[adsrps_pkg::PHASE_BITS-1:0];
    assign out_start  = m_axis_tdata[adsrps_pkg::PHASE_BITS];
    assign out_end    = m_axis_tdata[adsrps_pkg::PHASE_BITS+1];
    assign out_active = m_axis_tdata[adsrps_pkg::PHASE_BITS+2];

    // The active flag must agree with the reported phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_active == (out_phase != adsrps_pkg::PH_IDLE)))
        else $error("active flag disagrees with reported phase");

    // A start word always reports attack, and an end word always reports release.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_start) |-> (out_phase == adsrps_pkg::PH_ATTACK))
        else $error("start pulse outside attack");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_end) |-> (out_phase == adsrps_pkg::PH_RELEASE))
        else $error("end pulse outside release");

    // Nothing is shown on the result side straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind adsr_phase_sequencer_unit adsrps_checker #(
    .DURATION_BITS(DURATION_BITS)
) u_adsrps_checker (.*);
